/* src/php_pkg.sv */
// Packet header parser package: frame offsets, type codes, kind enums and
// the structs passed between the capture and result stages. No dependencies.

package php_pkg;

    // Ethernet / 802.1Q positions and codes
    localparam logic [7:0]  C_MIN_FRAME_LEN  = 8'd14;
    localparam logic [7:0]  C_POS_TYPE_HI    = 8'd12;
    localparam logic [7:0]  C_POS_TYPE_LO    = 8'd13;
    localparam logic [7:0]  C_POS_TCI_HI     = 8'd14;
    localparam logic [7:0]  C_POS_TCI_LO     = 8'd15;
    localparam logic [7:0]  C_POS_INNER_HI   = 8'd16;
    localparam logic [7:0]  C_POS_INNER_LO   = 8'd17;
    localparam logic [7:0]  C_L3_OFS_UNTAG   = 8'd14;
    localparam logic [7:0]  C_L3_OFS_TAG     = 8'd18;
    localparam logic [15:0] C_TYPE_VLAN      = 16'h8100;
    localparam logic [15:0] C_TYPE_IPV4      = 16'h0800;
    localparam logic [15:0] C_TYPE_ARP       = 16'h0806;

    // Offsets inside the IPv4 header
    localparam logic [7:0]  C_IP_OFS_IHL     = 8'd0;
    localparam logic [7:0]  C_IP_OFS_PROTO   = 8'd9;
    localparam logic [7:0]  C_IP_OFS_SRC     = 8'd12;
    localparam logic [7:0]  C_IP_OFS_DST     = 8'd16;
    localparam logic [7:0]  C_IP_HDR_LEN     = 8'd20;

    // Offsets inside the L4 header
    localparam logic [7:0]  C_L4_OFS_SPORT   = 8'd0;
    localparam logic [7:0]  C_L4_OFS_DPORT   = 8'd2;
    localparam logic [7:0]  C_L4_OFS_TCP_DO  = 8'd12;
    localparam logic [7:0]  C_TCP_HDR_LEN    = 8'd20;
    localparam logic [7:0]  C_UDP_HDR_LEN    = 8'd8;
    localparam logic [7:0]  C_ICMP_HDR_LEN   = 8'd8;

    localparam logic [7:0]  C_PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  C_PROTO_TCP      = 8'd6;
    localparam logic [7:0]  C_PROTO_UDP      = 8'd17;

    localparam logic [7:0]  C_COUNT_MAX      = 8'hFF;

    typedef enum logic [1:0] {
        L3_NONE = 2'd0,
        L3_IPV4 = 2'd1,
        L3_ARP  = 2'd2
    } t_l3_kind;

    typedef enum logic [1:0] {
        L4_NONE = 2'd0,
        L4_TCP  = 2'd1,
        L4_UDP  = 2'd2,
        L4_ICMP = 2'd3
    } t_l4_kind;

    // Per-frame header fields gathered byte by byte
    typedef struct packed {
        logic [7:0]  byte_count;
        logic [15:0] ether_kind;
        logic        tag_seen;
        logic [11:0] tag_id;
        logic [3:0]  header_words;
        logic [7:0]  proto;
        logic [31:0] ip_src;
        logic [31:0] ip_dst;
        logic [15:0] l4_sport;
        logic [15:0] l4_dport;
        logic [3:0]  tcp_offset;
    } t_frame;

    // Metadata result for one frame
    typedef struct packed {
        logic        status;
        logic        vlan_present;
        logic [11:0] vlan_id;
        t_l3_kind    l3_kind;
        t_l4_kind    l4_kind;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  payload_ofs;
        logic [31:0] tuple_hash;
    } t_meta;

    // Handshake between the capture stage and the result stage
    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_snap;

endpackage

/* src/php_if.sv */
// Channel interfaces of the packet header parser: the byte stream in and
// the per-frame metadata out. No dependencies.

interface php_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;

    modport source (output valid, output packet_byte, output last_byte, input ready);
    modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface php_meta_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic        vlan_present;
    logic [11:0] vlan_id;
    logic [1:0]  l3_kind;
    logic [1:0]  l4_kind;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  payload_ofs;
    logic [31:0] tuple_hash;

    modport source (
        output valid, input ready,
        output status, output vlan_present, output vlan_id, output l3_kind,
        output l4_kind, output ip_protocol, output source_address,
        output dest_address, output source_port, output dest_port,
        output payload_ofs, output tuple_hash
    );
    modport sink (
        input valid, output ready,
        input status, input vlan_present, input vlan_id, input l3_kind,
        input l4_kind, input ip_protocol, input source_address,
        input dest_address, input source_port, input dest_port,
        input payload_ofs, input tuple_hash
    );
endinterface

/* src/php_field_capture.sv */
// Input register and per-frame field capture. Holds the running header state
// and hands a snapshot of it on at the last byte. Uses php_pkg, php_byte_if.

module php_field_capture
    import php_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    php_byte_if.sink   i_byte,
    output t_snap      o_snap,
    input  logic       i_snap_rdy
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_frame     r_st;
    t_frame     n_st;
    logic       r_snap_vld;
    t_frame     r_snap;

    logic       snap_free;
    logic       adv;
    logic       in_ready;
    logic [7:0] pos;
    logic [7:0] b;
    logic [15:0] kind_lo;
    logic [7:0] l3;
    logic [7:0] rel3;
    logic [7:0] l4;
    logic [7:0] rel4;
    logic [3:0] hw;

    assign snap_free = !r_snap_vld || i_snap_rdy;
    // a last byte moves on only when the snapshot slot is free
    assign adv       = r_in_vld && (!r_in_last || snap_free);
    assign in_ready  = !r_in_vld || adv;
    assign i_byte.ready = in_ready;

    assign pos     = r_st.byte_count;
    assign b       = r_in_byte;
    assign kind_lo = {r_st.ether_kind[15:8], b};

    always_comb begin
        n_st = r_st;
        if (pos == C_POS_TYPE_HI) begin
            n_st.ether_kind = {b, 8'h00};
        end else if (pos == C_POS_TYPE_LO) begin
            if (kind_lo == C_TYPE_VLAN) begin
                n_st.tag_seen   = 1'b1;
                n_st.ether_kind = 16'h0000;
            end else begin
                n_st.ether_kind = kind_lo;
            end
        end else if (r_st.tag_seen && pos == C_POS_TCI_HI) begin
            n_st.tag_id = {b[3:0], 8'h00};
        end else if (r_st.tag_seen && pos == C_POS_TCI_LO) begin
            n_st.tag_id = {r_st.tag_id[11:8], b};
        end else if (r_st.tag_seen && pos == C_POS_INNER_HI) begin
            n_st.ether_kind = {b, 8'h00};
        end else if (r_st.tag_seen && pos == C_POS_INNER_LO) begin
            n_st.ether_kind = kind_lo;
        end

        l3   = n_st.tag_seen ? C_L3_OFS_TAG : C_L3_OFS_UNTAG;
        rel3 = pos - l3;
        // IHL taken on this very byte already moves the L4 offset
        hw   = (rel3 == C_IP_OFS_IHL) ? b[3:0] : r_st.header_words;
        l4   = l3 + {2'b00, hw, 2'b00};
        rel4 = pos - l4;

        if (pos >= l3) begin
            if (rel3 == C_IP_OFS_IHL) begin
                n_st.header_words = b[3:0];
            end else if (rel3 == C_IP_OFS_PROTO) begin
                n_st.proto = b;
            end else if (rel3 == C_IP_OFS_SRC) begin
                n_st.ip_src[31:24] = b;
            end else if (rel3 == C_IP_OFS_SRC + 8'd1) begin
                n_st.ip_src[23:16] = b;
            end else if (rel3 == C_IP_OFS_SRC + 8'd2) begin
                n_st.ip_src[15:8] = b;
            end else if (rel3 == C_IP_OFS_SRC + 8'd3) begin
                n_st.ip_src[7:0] = b;
            end else if (rel3 == C_IP_OFS_DST) begin
                n_st.ip_dst[31:24] = b;
            end else if (rel3 == C_IP_OFS_DST + 8'd1) begin
                n_st.ip_dst[23:16] = b;
            end else if (rel3 == C_IP_OFS_DST + 8'd2) begin
                n_st.ip_dst[15:8] = b;
            end else if (rel3 == C_IP_OFS_DST + 8'd3) begin
                n_st.ip_dst[7:0] = b;
            end

            if (pos >= l4) begin
                if (rel4 == C_L4_OFS_SPORT) begin
                    n_st.l4_sport[15:8] = b;
                end else if (rel4 == C_L4_OFS_SPORT + 8'd1) begin
                    n_st.l4_sport[7:0] = b;
                end else if (rel4 == C_L4_OFS_DPORT) begin
                    n_st.l4_dport[15:8] = b;
                end else if (rel4 == C_L4_OFS_DPORT + 8'd1) begin
                    n_st.l4_dport[7:0] = b;
                end else if (rel4 == C_L4_OFS_TCP_DO) begin
                    n_st.tcp_offset = b[7:4];
                end
            end
        end

        if (pos != C_COUNT_MAX) begin
            n_st.byte_count = pos + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_st       <= '0;
            r_snap_vld <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_vld <= i_byte.valid;
            end
            if (adv) begin
                r_st <= r_in_last ? t_frame'('0) : n_st;
            end
            if (adv && r_in_last) begin
                r_snap_vld <= 1'b1;
            end else if (i_snap_rdy) begin
                r_snap_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_byte.valid) begin
            r_in_byte <= i_byte.packet_byte;
            r_in_last <= i_byte.last_byte;
        end
        if (adv && r_in_last) begin
            r_snap <= n_st;
        end
    end

    assign o_snap.valid = r_snap_vld;
    assign o_snap.frame = r_snap;

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_last) |=> (r_st.byte_count == 8'd0 && !r_st.tag_seen))
        else $error("frame state not cleared after last byte");

    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_snap_vld && !i_snap_rdy) |=> (r_snap_vld && $stable(r_snap)))
        else $error("stalled snapshot changed");

    a_tag_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.tag_seen |-> (r_st.byte_count >= C_MIN_FRAME_LEN))
        else $error("tag flagged before the type field was complete");
`endif

endmodule

/* src/php_result_build.sv */
// Result stage: decodes a captured frame into metadata (kinds, length
// checks, payload offset, flow hash) and holds it in the output register.
// Uses php_pkg, php_meta_if.

module php_result_build
    import php_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_snap      i_snap,
    output logic       o_snap_rdy,
    php_meta_if.source o_meta
);

    t_meta      r_out;
    t_meta      n_out;
    logic       r_out_vld;
    logic       out_free;

    t_frame     f;
    logic [7:0] l3;
    logic [7:0] l4;
    logic [15:0] sp;
    logic [15:0] dp;

    assign out_free   = !r_out_vld || o_meta.ready;
    assign o_snap_rdy = out_free;
    assign f          = i_snap.frame;

    always_comb begin
        n_out = '0;
        l3    = f.tag_seen ? C_L3_OFS_TAG : C_L3_OFS_UNTAG;
        l4    = l3 + {2'b00, f.header_words, 2'b00};
        sp    = 16'h0000;
        dp    = 16'h0000;
        if (f.byte_count < C_MIN_FRAME_LEN) begin
            n_out.status = 1'b1;
        end else begin
            n_out.vlan_present = f.tag_seen;
            n_out.vlan_id      = f.tag_id;
            if (f.ether_kind == C_TYPE_IPV4 && f.byte_count >= l3 + C_IP_HDR_LEN) begin
                n_out.l3_kind        = L3_IPV4;
                n_out.ip_protocol    = f.proto;
                n_out.source_address = f.ip_src;
                n_out.dest_address   = f.ip_dst;
                if (f.proto == C_PROTO_TCP && f.byte_count >= l4 + C_TCP_HDR_LEN) begin
                    n_out.l4_kind     = L4_TCP;
                    sp                = f.l4_sport;
                    dp                = f.l4_dport;
                    n_out.payload_ofs = l4 + {2'b00, f.tcp_offset, 2'b00};
                end else if (f.proto == C_PROTO_UDP
                             && f.byte_count >= l4 + C_UDP_HDR_LEN) begin
                    n_out.l4_kind     = L4_UDP;
                    sp                = f.l4_sport;
                    dp                = f.l4_dport;
                    n_out.payload_ofs = l4 + C_UDP_HDR_LEN;
                end else if (f.proto == C_PROTO_ICMP) begin
                    n_out.l4_kind     = L4_ICMP;
                    n_out.payload_ofs = l4 + C_ICMP_HDR_LEN;
                end
                n_out.source_port = sp;
                n_out.dest_port   = dp;
                n_out.tuple_hash  = f.ip_src ^ f.ip_dst ^ {sp, dp} ^ {24'h0, f.proto};
            end else if (f.ether_kind == C_TYPE_ARP) begin
                n_out.l3_kind = L3_ARP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= i_snap.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && i_snap.valid) begin
            r_out <= n_out;
        end
    end

    assign o_meta.valid          = r_out_vld;
    assign o_meta.status         = r_out.status;
    assign o_meta.vlan_present   = r_out.vlan_present;
    assign o_meta.vlan_id        = r_out.vlan_id;
    assign o_meta.l3_kind        = r_out.l3_kind;
    assign o_meta.l4_kind        = r_out.l4_kind;
    assign o_meta.ip_protocol    = r_out.ip_protocol;
    assign o_meta.source_address = r_out.source_address;
    assign o_meta.dest_address   = r_out.dest_address;
    assign o_meta.source_port    = r_out.source_port;
    assign o_meta.dest_port      = r_out.dest_port;
    assign o_meta.payload_ofs    = r_out.payload_ofs;
    assign o_meta.tuple_hash     = r_out.tuple_hash;

`ifndef SYNTHESIS
    a_short_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status) |->
            (r_out.l3_kind == L3_NONE && r_out.tuple_hash == 32'h0 && !r_out.vlan_present))
        else $error("short frame result carries fields");

    a_l4_needs_ipv4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.l4_kind != L4_NONE) |-> (r_out.l3_kind == L3_IPV4))
        else $error("L4 kind without IPv4");

    a_offset_needs_l4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.payload_ofs != 8'd0) |-> (r_out.l4_kind != L4_NONE))
        else $error("payload offset without L4");
`endif

endmodule

/* src/packet_header_parser.sv */
// Channel  | Dir | Payload                                    | Transfer
// i_byte   | in  | packet_byte[7:0], last_byte                | valid && ready
// o_meta   | out | status .. tuple_hash (one per frame)       | valid && ready
//
// One byte per cycle is accepted unless a last byte waits to move on; once
// taken, a frame's result passes the snapshot register, then the result register.
// Reset (i_rst_n low, synchronous) empties every stage and clears frame state.
// A stalled o_meta holds its result; bytes keep flowing until a last byte
// finds the snapshot slot and output register both full and waits in the
// input register.
// Top level of the packet header parser. Uses php_pkg, php_if,
// php_field_capture, php_result_build.

module packet_header_parser
    import php_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    php_byte_if.sink   i_byte,
    php_meta_if.source o_meta
);

    t_snap snap;
    logic  snap_rdy;

    php_field_capture u_capture (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_byte),
        .o_snap     (snap),
        .i_snap_rdy (snap_rdy)
    );

    php_result_build u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_snap     (snap),
        .o_snap_rdy (snap_rdy),
        .o_meta     (o_meta)
    );

endmodule

/* verif/packet_header_parser_tb.sv */
`timescale 1ns / 100ps
// Testbench for packet_header_parser: drives whole frames byte by byte and
// checks every metadata result against a field-level header predictor.
// Depends on php_pkg, php_if and the packet_header_parser RTL.

module packet_header_parser_tb;
    import php_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    php_byte_if byte_ch ();
    php_meta_if meta_ch ();

    packet_header_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_meta  (meta_ch)
    );

    always #10 i_clk = ~i_clk;

    t_frame     hdr_state;          // header fields gathered so far
    t_meta      meta_expected[$];   // predicted results, oldest first
    logic [7:0] frame_bytes[$];     // frame under construction
    int         mismatches = 0;
    int         bytes_sent = 0;
    bit         steady = 1'b0;      // no idling on either side while set

    // ---------------------------------------------------------------
    // Header predictor
    // ---------------------------------------------------------------
    function automatic void capture_header_byte(logic [7:0] b);
        int pos, l3, l4, r, q;
        pos = int'(hdr_state.byte_count);
        if (pos == C_POS_TYPE_HI) begin
            hdr_state.ether_kind = {b, 8'h00};
        end else if (pos == C_POS_TYPE_LO) begin
            hdr_state.ether_kind[7:0] = b;
            if (hdr_state.ether_kind == C_TYPE_VLAN) begin
                hdr_state.tag_seen   = 1'b1;
                hdr_state.ether_kind = '0;
            end
        end else if (hdr_state.tag_seen && pos == C_POS_TCI_HI) begin
            hdr_state.tag_id = {b[3:0], 8'h00};
        end else if (hdr_state.tag_seen && pos == C_POS_TCI_LO) begin
            hdr_state.tag_id[7:0] = b;
        end else if (hdr_state.tag_seen && pos == C_POS_INNER_HI) begin
            hdr_state.ether_kind = {b, 8'h00};
        end else if (hdr_state.tag_seen && pos == C_POS_INNER_LO) begin
            hdr_state.ether_kind[7:0] = b;
        end

        l3 = int'(hdr_state.tag_seen ? C_L3_OFS_TAG : C_L3_OFS_UNTAG);
        if (pos >= l3) begin
            r = pos - l3;
            if (r == C_IP_OFS_IHL)
                hdr_state.header_words = b[3:0];
            else if (r == C_IP_OFS_PROTO)
                hdr_state.proto = b;
            else if (r >= 12 && r <= 15)
                hdr_state.ip_src |= 32'(b) << (8 * (15 - r));
            else if (r >= 16 && r <= 19)
                hdr_state.ip_dst |= 32'(b) << (8 * (19 - r));

            // IHL just written counts already (small IHL overlaps L4 and IP)
            l4 = l3 + hdr_state.header_words * 4;
            if (pos >= l4) begin
                q = pos - l4;
                case (q)
                    0:  hdr_state.l4_sport[15:8] = b;
                    1:  hdr_state.l4_sport[7:0]  = b;
                    2:  hdr_state.l4_dport[15:8] = b;
                    3:  hdr_state.l4_dport[7:0]  = b;
                    12: hdr_state.tcp_offset     = b[7:4];
                    default: ;
                endcase
            end
        end
        if (hdr_state.byte_count != C_COUNT_MAX)
            hdr_state.byte_count = hdr_state.byte_count + 8'd1;
    endfunction

    function automatic t_meta predict_meta();
        t_meta m;
        int    len, l3, l4;
        m   = '0;
        len = int'(hdr_state.byte_count);
        if (len < C_MIN_FRAME_LEN) begin
            m.status = 1'b1;
            return m;
        end
        l3 = int'(hdr_state.tag_seen ? C_L3_OFS_TAG : C_L3_OFS_UNTAG);
        if (hdr_state.ether_kind == C_TYPE_IPV4 && len >= l3 + C_IP_HDR_LEN) begin
            m.l3_kind        = L3_IPV4;
            m.ip_protocol    = hdr_state.proto;
            m.source_address = hdr_state.ip_src;
            m.dest_address   = hdr_state.ip_dst;
            l4 = l3 + hdr_state.header_words * 4;
            if (hdr_state.proto == C_PROTO_TCP && len >= l4 + C_TCP_HDR_LEN) begin
                m.l4_kind     = L4_TCP;
                m.source_port = hdr_state.l4_sport;
                m.dest_port   = hdr_state.l4_dport;
                m.payload_ofs = 8'(l4 + hdr_state.tcp_offset * 4);
            end else if (hdr_state.proto == C_PROTO_UDP && len >= l4 + C_UDP_HDR_LEN) begin
                m.l4_kind     = L4_UDP;
                m.source_port = hdr_state.l4_sport;
                m.dest_port   = hdr_state.l4_dport;
                m.payload_ofs = 8'(l4 + C_UDP_HDR_LEN);
            end else if (hdr_state.proto == C_PROTO_ICMP) begin
                m.l4_kind     = L4_ICMP;
                m.payload_ofs = 8'(l4 + C_ICMP_HDR_LEN);
            end
            m.tuple_hash = m.source_address ^ m.dest_address
                         ^ {m.source_port, m.dest_port} ^ 32'(m.ip_protocol);
        end else if (hdr_state.ether_kind == C_TYPE_ARP) begin
            m.l3_kind = L3_ARP;
        end
        m.vlan_present = hdr_state.tag_seen;
        m.vlan_id      = hdr_state.tag_id;
        return m;
    endfunction

    // ---------------------------------------------------------------
    // Frame construction
    // ---------------------------------------------------------------
    function automatic void build_noise(int len);
        frame_bytes.delete();
        repeat (len) frame_bytes.push_back(8'($urandom));
    endfunction

    // Random content with the given headers laid on top, cut to len bytes
    function automatic void build_frame(bit with_tag, logic [11:0] vid, logic [15:0] etype,
                                        logic [3:0] ihl, logic [7:0] proto,
                                        logic [31:0] sa, logic [31:0] da,
                                        logic [15:0] sp, logic [15:0] dp,
                                        logic [3:0] data_ofs, int len);
        int l3, l4;
        build_noise(len > 100 ? len : 100);
        l3 = int'(with_tag ? C_L3_OFS_TAG : C_L3_OFS_UNTAG);
        if (with_tag) begin
            frame_bytes[12] = C_TYPE_VLAN[15:8];
            frame_bytes[13] = C_TYPE_VLAN[7:0];
            frame_bytes[14] = {4'($urandom), vid[11:8]};
            frame_bytes[15] = vid[7:0];
        end
        frame_bytes[l3 - 2] = etype[15:8];
        frame_bytes[l3 - 1] = etype[7:0];
        frame_bytes[l3]     = {4'h4, ihl};
        frame_bytes[l3 + 9] = proto;
        for (int k = 0; k < 4; k++) begin
            frame_bytes[l3 + 12 + k] = sa[31 - 8 * k -: 8];
            frame_bytes[l3 + 16 + k] = da[31 - 8 * k -: 8];
        end
        l4 = l3 + ihl * 4;
        frame_bytes[l4]      = sp[15:8];
        frame_bytes[l4 + 1]  = sp[7:0];
        frame_bytes[l4 + 2]  = dp[15:8];
        frame_bytes[l4 + 3]  = dp[7:0];
        frame_bytes[l4 + 12] = {data_ofs, 4'($urandom)};
        while (frame_bytes.size() > len) frame_bytes.pop_back();
    endfunction

    // ---------------------------------------------------------------
    // Driving and checking
    // ---------------------------------------------------------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_byte(logic [7:0] b, bit is_last);
        int gap;
        gap = idle_len();
        if (gap != 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.packet_byte <= b;
        byte_ch.last_byte   <= is_last;
        do @(posedge i_clk); while (!byte_ch.ready);
        // transfer taken at this edge
        bytes_sent++;
        capture_header_byte(b);
        if (is_last) begin
            meta_expected.push_back(predict_meta());
            hdr_state = '0;
        end
    endtask

    task automatic send_frame();
        int n;
        n = frame_bytes.size();
        for (int i = 0; i < n; i++) send_byte(frame_bytes[i], i == n - 1);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Output stalls
    initial begin : meta_ready_gen
        int hold;
        hold = 0;
        meta_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (steady) begin
                hold = 0;
                meta_ch.ready <= 1'b1;
            end else if (hold != 0) begin
                hold--;
                meta_ch.ready <= 1'b0;
            end else begin
                hold = idle_len();
                meta_ch.ready <= (hold == 0);
                if (hold != 0) hold--;
            end
        end
    end

    always @(posedge i_clk) begin : meta_check
        t_meta want;
        if (i_rst_n && meta_ch.valid && meta_ch.ready) begin
            if (meta_expected.size() == 0) begin
                $error("result transfer with no frame outstanding");
                mismatches++;
            end else begin
                want = meta_expected.pop_front();
                check_field("status",         want.status,         meta_ch.status);
                check_field("vlan_present",   want.vlan_present,   meta_ch.vlan_present);
                check_field("vlan_id",        want.vlan_id,        meta_ch.vlan_id);
                check_field("l3_kind",        want.l3_kind,        meta_ch.l3_kind);
                check_field("l4_kind",        want.l4_kind,        meta_ch.l4_kind);
                check_field("ip_protocol",    want.ip_protocol,    meta_ch.ip_protocol);
                check_field("source_address", want.source_address, meta_ch.source_address);
                check_field("dest_address",   want.dest_address,   meta_ch.dest_address);
                check_field("source_port",    want.source_port,    meta_ch.source_port);
                check_field("dest_port",      want.dest_port,      meta_ch.dest_port);
                check_field("payload_ofs",    want.payload_ofs,    meta_ch.payload_ofs);
                check_field("tuple_hash",     want.tuple_hash,     meta_ch.tuple_hash);
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_short_frames();
        frame_bytes.delete();
        frame_bytes.push_back(8'hFF);
        send_frame();
        build_noise(13);
        send_frame();
        build_noise(5);
        send_frame();
        // minimum length, all zero: parsed, no L3
        build_noise(14);
        foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
        send_frame();
    endtask

    task automatic test_ipv4_l4();
        build_frame(1'b0, 12'h000, C_TYPE_IPV4, 4'd5, C_PROTO_TCP, 32'hFFFF_FFFF, 32'h0,
                    16'hFFFF, 16'h0000, 4'd5, 54);
        send_frame();
        build_frame(1'b0, 12'h000, C_TYPE_IPV4, 4'd15, C_PROTO_TCP, 32'h0A00_0001,
                    32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 4'd15, 94);
        send_frame();
        // UDP at exactly its minimum length
        build_frame(1'b0, 12'h000, C_TYPE_IPV4, 4'd5, C_PROTO_UDP, $urandom, $urandom,
                    16'h8001, 16'h0035, 4'd0, 42);
        send_frame();
        // ICMP needs no bytes past the IP header
        build_frame(1'b0, 12'h000, C_TYPE_IPV4, 4'd5, C_PROTO_ICMP, $urandom, $urandom,
                    16'h0, 16'h0, 4'd0, 34);
        send_frame();
        build_frame(1'b0, 12'h000, C_TYPE_IPV4, 4'd5, 8'd47, $urandom, $urandom,
                    16'($urandom), 16'($urandom), 4'd5, 34);
        send_frame();
    endtask

    task automatic test_arp_and_other();
        build_frame(1'b0, 12'h000, C_TYPE_ARP, 4'd5, 8'd0, 32'h0, 32'h0, 16'h0, 16'h0,
                    4'd0, 14);
        send_frame();
        build_frame(1'b0, 12'h000, C_TYPE_ARP, 4'($urandom), 8'($urandom), $urandom,
                    $urandom, 16'($urandom), 16'($urandom), 4'($urandom), 30);
        send_frame();
        build_frame(1'b0, 12'h000, 16'h86DD, 4'd5, C_PROTO_TCP, $urandom, $urandom,
                    16'($urandom), 16'($urandom), 4'd5, 34);
        send_frame();
    endtask

    task automatic test_vlan();
        build_frame(1'b1, 12'hFFF, C_TYPE_IPV4, 4'd5, C_PROTO_UDP, $urandom, $urandom,
                    16'($urandom), 16'($urandom), 4'd0, 46);
        send_frame();
        // largest payload offset: VLAN tag, maximum IHL and data offset
        build_frame(1'b1, 12'h5A5, C_TYPE_IPV4, 4'd15, C_PROTO_TCP, $urandom, $urandom,
                    16'($urandom), 16'($urandom), 4'd15, 98);
        send_frame();
        build_frame(1'b1, 12'h000, C_TYPE_ARP, 4'd5, 8'd0, 32'h0, 32'h0, 16'h0, 16'h0,
                    4'd0, 22);
        send_frame();
        // frames with a tag cut inside the tag or the inner type
        build_frame(1'b1, 12'h123, C_TYPE_ARP, 4'd5, 8'd0, 32'h0, 32'h0, 16'h0, 16'h0,
                    4'd0, 15);
        send_frame();
        build_frame(1'b1, 12'hABC, C_TYPE_ARP, 4'd5, 8'd0, 32'h0, 32'h0, 16'h0, 16'h0,
                    4'd0, 17);
        send_frame();
    endtask

    task automatic test_length_checks();
        // IPv4 one byte short of its header
        build_frame(1'b0, 12'h000, C_TYPE_IPV4, 4'd5, C_PROTO_TCP, $urandom, $urandom,
                    16'($urandom), 16'($urandom), 4'd5, 33);
        send_frame();
        // L4 checks fail but L3 fields are still reported
        build_frame(1'b0, 12'h000, C_TYPE_IPV4, 4'd5, C_PROTO_TCP, $urandom, $urandom,
                    16'($urandom), 16'($urandom), 4'd5, 53);
        send_frame();
        build_frame(1'b1, 12'($urandom), C_TYPE_IPV4, 4'd6, C_PROTO_UDP, $urandom, $urandom,
                    16'($urandom), 16'($urandom), 4'd0, 49);
        send_frame();
    endtask

    task automatic test_small_ihl();
        build_frame(1'b0, 12'h000, C_TYPE_IPV4, 4'd0, C_PROTO_UDP, $urandom, $urandom,
                    16'($urandom), 16'($urandom), 4'd3, 40);
        send_frame();
        build_frame(1'b1, 12'($urandom), C_TYPE_IPV4, 4'd4, C_PROTO_TCP, $urandom, $urandom,
                    16'($urandom), 16'($urandom), 4'd2, 50);
        send_frame();
    endtask

    task automatic test_long_frame();
        steady = 1'b1;
        build_frame(1'b0, 12'h000, C_TYPE_IPV4, 4'd5, C_PROTO_TCP, $urandom, $urandom,
                    16'($urandom), 16'($urandom), 4'd8, 258);
        send_frame();
        steady = 1'b0;
    endtask

    task automatic test_random_frames();
        int start_bytes, kind, sel, len, l3, l4;
        bit with_tag;
        logic [7:0] proto;
        logic [3:0] ihl, data_ofs;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < 200) begin
            steady = ($urandom_range(0, 4) == 0);
            with_tag = ($urandom_range(0, 9) < 3);
            l3 = int'(with_tag ? C_L3_OFS_TAG : C_L3_OFS_UNTAG);
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                sel = $urandom_range(0, 9);
                proto = (sel < 4) ? C_PROTO_TCP : (sel < 7) ? C_PROTO_UDP :
                        (sel < 8) ? C_PROTO_ICMP : 8'($urandom);
                ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5;
                data_ofs = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'd5;
                l4 = l3 + ihl * 4;
                len = l4 + ((proto == C_PROTO_TCP) ? 20 : 8) + $urandom_range(0, 8);
                if (len < l3 + 20) len = l3 + 20 + $urandom_range(0, 8);
                if ($urandom_range(0, 99) < 15) len = $urandom_range(14, len);
                build_frame(with_tag, 12'($urandom), C_TYPE_IPV4, ihl, proto, $urandom,
                            $urandom, 16'($urandom), 16'($urandom), data_ofs, len);
            end else if (kind < 80) begin
                build_frame(with_tag, 12'($urandom), C_TYPE_ARP, 4'($urandom), 8'($urandom),
                            $urandom, $urandom, 16'($urandom), 16'($urandom), 4'($urandom),
                            $urandom_range(14, 60));
            end else if (kind < 98) begin
                build_noise($urandom_range(1, 40));
            end else begin
                build_frame(with_tag, 12'($urandom), C_TYPE_IPV4, 4'd5, C_PROTO_TCP,
                            $urandom, $urandom, 16'($urandom), 16'($urandom), 4'($urandom),
                            $urandom_range(240, 300));
            end
            send_frame();
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        byte_ch.valid       <= 1'b0;
        byte_ch.packet_byte <= '0;
        byte_ch.last_byte   <= 1'b0;
        hdr_state = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_frames();
        test_ipv4_l4();
        test_arp_and_other();
        test_vlan();
        test_length_checks();
        test_small_ihl();
        test_long_frame();
        test_random_frames();

        byte_ch.valid <= 1'b0;
        while (meta_expected.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[packet_header_parser] OK");
        end else begin
            $display("[packet_header_parser] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #(64'd12_000_000);
        $display("[packet_header_parser] ERROR");
        $finish;
    end

endmodule

/* files.f */
src/php_pkg.sv
src/php_if.sv
src/php_field_capture.sv
src/php_result_build.sv
src/packet_header_parser.sv
verif/packet_header_parser_tb.sv
